// File: rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg: shared definitions for the shell command lexer
// Token codes, character codes, size constants and the result record.
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int MAX_TOKEN_COUNT = 64;
    localparam int MAX_VALUE_LEN   = 64;

    localparam int LEN_W = $clog2(MAX_VALUE_LEN);
    localparam int CNT_W = $clog2(MAX_TOKEN_COUNT);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_VALUE_LEN - 1);
    localparam logic [CNT_W-1:0] TOT_LIMIT = CNT_W'(MAX_TOKEN_COUNT - 1);

    // Result queue size. It must be a power of two, and at least 4.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = PTR_W + 1;

    localparam logic [3:0] TT_WORD     = 4'd0;
    localparam logic [3:0] TT_NUMBER   = 4'd1;
    localparam logic [3:0] TT_STRING   = 4'd2;
    localparam logic [3:0] TT_OPERATOR = 4'd3;
    localparam logic [3:0] TT_PIPE     = 4'd4;
    localparam logic [3:0] TT_IN       = 4'd5;
    localparam logic [3:0] TT_OUT      = 4'd6;
    localparam logic [3:0] TT_APPEND   = 4'd7;
    localparam logic [3:0] TT_SEMI     = 4'd8;
    localparam logic [3:0] TT_EOF      = 4'd9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    typedef struct packed {
        logic [3:0] token_type;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       token_start;
        logic       last_of_input;
    } result_t;

    // Results produced by one item in one cycle: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(input logic [3:0] ttype, input logic [7:0] b,
                                            input logic bvalid, input logic start);
        result_t r;
        r.token_type    = ttype;
        r.value_byte    = bvalid ? b : CH_NUL;
        r.byte_valid    = bvalid;
        r.token_start   = start;
        r.last_of_input = 1'b0;
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQ) ||
               (c == CH_STAR) || (c == CH_PCT) || (c == CH_AMP);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQ) || (c == CH_SQ);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return !is_blank(c) && (c != CH_PIPE) && (c != CH_LT) && (c != CH_GT) &&
               (c != CH_SEMI) && !is_quote(c) && !is_op(c);
    endfunction

endpackage

// File: rtl/scl_core.sv
// ----------------------------------------------------------------------------
// scl_core: lexer state and per-character token logic
// Sorts one registered item per cycle while go is high and produces up to two results.
// ----------------------------------------------------------------------------
module scl_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic            action,
    input  logic [7:0]      char_byte,
    output scl_pkg::push_t  push
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_WORD    = 6'b000010,
        M_NUMBER  = 6'b000100,
        M_STRING  = 6'b001000,
        M_STRFULL = 6'b010000,
        M_PENDGT  = 6'b100000
    } lex_mode_t;

    lex_mode_t                     mode_reg, mode_next;
    logic                          quote_reg, quote_next;
    logic [scl_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [scl_pkg::CNT_W-1:0]     total_reg, total_next;

    logic                          do_sort;
    logic                          sort_en;
    scl_pkg::result_t              sort_res;
    scl_pkg::result_t              res0, res1;
    logic [1:0]                    cnt;
    logic [7:0]                    quote_ch;

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        len_next   = len_reg;
        total_next = total_reg;
        cnt        = 2'd0;
        res0       = scl_pkg::make_result(scl_pkg::TT_WORD, scl_pkg::CH_NUL, 1'b0, 1'b0);
        res1       = res0;
        sort_res   = res0;
        do_sort    = 1'b0;
        sort_en    = 1'b0;
        quote_ch   = quote_reg ? scl_pkg::CH_SQ : scl_pkg::CH_DQ;

        if (action)
        begin
            // End of line: flush a waiting '>' and close with the EOF token.
            if (mode_reg == M_PENDGT)
            begin
                res0 = scl_pkg::make_result(scl_pkg::TT_OUT, scl_pkg::CH_GT, 1'b1, 1'b1);
                res1 = scl_pkg::make_result(scl_pkg::TT_EOF, scl_pkg::CH_NUL, 1'b0, 1'b1);
                cnt  = 2'd2;
            end
            else
            begin
                res0 = scl_pkg::make_result(scl_pkg::TT_EOF, scl_pkg::CH_NUL, 1'b0, 1'b1);
                cnt  = 2'd1;
            end
            mode_next  = M_IDLE;
            quote_next = 1'b0;
            len_next   = '0;
            total_next = '0;
        end
        else if (char_byte != scl_pkg::CH_NUL)
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (scl_pkg::is_word(char_byte) && (len_reg < scl_pkg::LEN_LIMIT))
                    begin
                        len_next = len_reg + scl_pkg::LEN_W'(1);
                        res0 = scl_pkg::make_result(scl_pkg::TT_WORD, char_byte, 1'b1, 1'b0);
                        cnt  = 2'd1;
                    end
                    else
                    begin
                        do_sort = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (scl_pkg::is_digit(char_byte) && (len_reg < scl_pkg::LEN_LIMIT))
                    begin
                        len_next = len_reg + scl_pkg::LEN_W'(1);
                        res0 = scl_pkg::make_result(scl_pkg::TT_NUMBER, char_byte, 1'b1,
                                                    1'b0);
                        cnt  = 2'd1;
                    end
                    else
                    begin
                        do_sort = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (char_byte == quote_ch)
                    begin
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        len_next = len_reg + scl_pkg::LEN_W'(1);
                        if (len_next >= scl_pkg::LEN_LIMIT)
                        begin
                            mode_next = M_STRFULL;
                        end
                        res0 = scl_pkg::make_result(scl_pkg::TT_STRING, char_byte, 1'b1,
                                                    1'b0);
                        cnt  = 2'd1;
                    end
                end
                M_STRFULL:
                begin
                    // A full string still swallows its closing quote.
                    if (char_byte == quote_ch)
                    begin
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_sort = 1'b1;
                    end
                end
                M_PENDGT:
                begin
                    if (char_byte == scl_pkg::CH_GT)
                    begin
                        mode_next = M_IDLE;
                        res0 = scl_pkg::make_result(scl_pkg::TT_APPEND, char_byte, 1'b1,
                                                    1'b1);
                        res1 = scl_pkg::make_result(scl_pkg::TT_APPEND, char_byte, 1'b1,
                                                    1'b0);
                        cnt  = 2'd2;
                    end
                    else
                    begin
                        res0 = scl_pkg::make_result(scl_pkg::TT_OUT, scl_pkg::CH_GT, 1'b1,
                                                    1'b1);
                        cnt     = 2'd1;
                        do_sort = 1'b1;
                    end
                end
                default:
                begin
                    do_sort = 1'b1;
                end
            endcase

            // A non-blank character met between tokens starts a new one, unless the line
            // already holds the most tokens allowed.
            if (do_sort)
            begin
                mode_next = M_IDLE;
                if ((total_reg < scl_pkg::TOT_LIMIT) && !scl_pkg::is_blank(char_byte))
                begin
                    total_next = total_reg + scl_pkg::CNT_W'(1);
                    if (char_byte == scl_pkg::CH_PIPE)
                    begin
                        sort_res = scl_pkg::make_result(scl_pkg::TT_PIPE, char_byte, 1'b1,
                                                        1'b1);
                        sort_en  = 1'b1;
                    end
                    else if (char_byte == scl_pkg::CH_LT)
                    begin
                        sort_res = scl_pkg::make_result(scl_pkg::TT_IN, char_byte, 1'b1, 1'b1);
                        sort_en  = 1'b1;
                    end
                    else if (char_byte == scl_pkg::CH_SEMI)
                    begin
                        sort_res = scl_pkg::make_result(scl_pkg::TT_SEMI, char_byte, 1'b1,
                                                        1'b1);
                        sort_en  = 1'b1;
                    end
                    else if (char_byte == scl_pkg::CH_GT)
                    begin
                        mode_next = M_PENDGT;
                    end
                    else if (scl_pkg::is_quote(char_byte))
                    begin
                        mode_next  = M_STRING;
                        quote_next = (char_byte == scl_pkg::CH_SQ);
                        len_next   = '0;
                        sort_res   = scl_pkg::make_result(scl_pkg::TT_STRING, scl_pkg::CH_NUL,
                                                          1'b0, 1'b1);
                        sort_en    = 1'b1;
                    end
                    else if (scl_pkg::is_op(char_byte))
                    begin
                        sort_res = scl_pkg::make_result(scl_pkg::TT_OPERATOR, char_byte, 1'b1,
                                                        1'b1);
                        sort_en  = 1'b1;
                    end
                    else if (scl_pkg::is_digit(char_byte))
                    begin
                        mode_next = M_NUMBER;
                        len_next  = scl_pkg::LEN_W'(1);
                        sort_res  = scl_pkg::make_result(scl_pkg::TT_NUMBER, char_byte, 1'b1,
                                                         1'b1);
                        sort_en   = 1'b1;
                    end
                    else
                    begin
                        mode_next = M_WORD;
                        len_next  = scl_pkg::LEN_W'(1);
                        sort_res  = scl_pkg::make_result(scl_pkg::TT_WORD, char_byte, 1'b1,
                                                         1'b1);
                        sort_en   = 1'b1;
                    end
                end
                if (sort_en)
                begin
                    if (cnt == 2'd0)
                    begin
                        res0 = sort_res;
                    end
                    else
                    begin
                        res1 = sort_res;
                    end
                    cnt = cnt + 2'd1;
                end
            end
        end

        if (cnt == 2'd2)
        begin
            res1.last_of_input = 1'b1;
        end
        else if (cnt == 2'd1)
        begin
            res0.last_of_input = 1'b1;
        end
    end

    assign push.count  = go ? cnt : 2'd0;
    assign push.first  = res0;
    assign push.second = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            quote_reg <= 1'b0;
            len_reg   <= '0;
            total_reg <= '0;
        end
        else if (go)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            len_reg   <= len_next;
            total_reg <= total_next;
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= scl_pkg::TOT_LIMIT)
        else $error("token count passed its limit");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && action) |=> (mode_reg == M_IDLE) && (total_reg == '0) && (len_reg == '0))
        else $error("end of line did not return the lexer to idle");

    a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == M_WORD) || (mode_reg == M_NUMBER)) |-> (len_reg != '0))
        else $error("open word or number holds no bytes");

endmodule

// File: rtl/scl_out_fifo.sv
// ----------------------------------------------------------------------------
// scl_out_fifo: result queue
// Takes up to two results a cycle from the lexer and hands one per transfer.
// ----------------------------------------------------------------------------
module scl_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  scl_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output scl_pkg::result_t  out_data
);

    scl_pkg::result_t                 entry_reg [scl_pkg::FIFO_DEPTH];
    logic [scl_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [scl_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [scl_pkg::FCNT_W-1:0]       count_reg, count_next;
    logic                             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Room for a worst-case item, judged without counting this cycle's pop.
    assign room = (count_reg <= scl_pkg::FCNT_W'(scl_pkg::FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + scl_pkg::PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + scl_pkg::PTR_W'(pop);
    assign count_next  = count_reg + scl_pkg::FCNT_W'(push.count)
                         - scl_pkg::FCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + scl_pkg::PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= scl_pkg::FCNT_W'(scl_pkg::FIFO_DEPTH))
        else $error("result queue overflowed");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results written without room");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// File: rtl/shell_command_lexer.sv
// ----------------------------------------------------------------------------
// shell_command_lexer: streaming shell command-line lexer
// Input channel (in_valid/in_stall) carries one character or an end-of-line
// mark per transfer. Output channel (out_valid/out_stall) carries one token
// byte per transfer with type, start mark and last-of-input mark; an item
// makes zero, one or two results.
// Throughput: one item per cycle while in_stall is low. The input register
// feeds the lexer, whose results go into a four-entry result queue; the lexer
// advances only while the queue holds at most two results, so a stalled
// receiver fills the queue and then raises in_stall. Items that make two
// results ('>>', '>' before another token, '>' at end of line) can raise
// in_stall when the receiver takes less than one result per cycle.
// Reset: the lexer is idle between tokens with no tokens counted, the queue
// is empty, and in_stall is low. End of line returns the lexer to that state.
// ----------------------------------------------------------------------------
module shell_command_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_type,
    output logic [7:0]  value_byte,
    output logic        byte_valid,
    output logic        token_start,
    output logic        last_of_input
);

    logic              item_valid_reg;
    logic              action_reg;
    logic [7:0]        char_reg;
    logic              room;
    logic              go;
    scl_pkg::push_t    push;
    scl_pkg::result_t  out_data;

    assign go       = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg <= action;
            char_reg   <= char_byte;
        end
    end

    scl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .action    (action_reg),
        .char_byte (char_reg),
        .push      (push)
    );

    scl_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign token_type    = out_data.token_type;
    assign value_byte    = out_data.value_byte;
    assign byte_valid    = out_data.byte_valid;
    assign token_start   = out_data.token_start;
    assign last_of_input = out_data.last_of_input;

endmodule
